// ----- design/nsr_pkg.sv -----
// shared constants and types for the newton square root block
package nsr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd6;

  localparam int unsigned MAX_ITER_DEFAULT = 32;
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_UPDATE,
    ST_CHECK,
    ST_DONE
  } nsr_state_e;

endpackage

// ----- design/nsr_if.sv -----
// channel interfaces: radicand input, result output and tolerance write
interface nsr_in_if;
  import nsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] radicand;
  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

interface nsr_out_if;
  import nsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] root;
  logic              not_converged;
  modport source (output valid, output root, output not_converged, input ready);
  modport sink (input valid, input root, input not_converged, output ready);
endinterface

interface nsr_cfg_if;
  import nsr_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] tolerance;
  modport source (output valid, output tolerance, input ready);
  modport sink (input valid, input tolerance, output ready);
endinterface

// ----- design/nsr_divider.sv -----
// restoring divider producing one quotient bit per cycle
module nsr_divider #(
  parameter int unsigned DVD_W = 48,
  parameter int unsigned DVS_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVD_W-1:0] dvd_q;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = trial >= {1'b0, divisor_i};
  end

  assign done_o     = busy_q && (cnt_q == CNT_W'(1));
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // dividend bits shift out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
  end

endmodule

// ----- design/newton_square_root.sv -----
// top level: square root of an unsigned fixed-point value by newton iteration
//
// rad_i carries one radicand per transaction (unsigned, FRACTION_BITS fraction
// bits in a 32-bit word); res_o returns one root in the same format together
// with not_converged. cfg_i writes the tolerance register; the user is to write
// it only while the block is idle, which is not enforced; it is always ready.
// the guess starts at 1.0 and each newton step divides the radicand, shifted
// up by FRACTION_BITS, by the guess in a restoring divider that yields one
// quotient bit per cycle. an item needs 1 to MAX_ITERATIONS steps; the
// result is then handed over to the output register and the block returns
// to idle to take the next radicand.
// one radicand is worked on at a time; rad_i.ready is high only while no item
// is in flight. the result sits in an output register, so a new radicand is
// taken while the previous result still waits; if the receiver stalls for
// longer than a whole item, the finished root waits inside until res_o frees.
// reset clears the control state and sets the tolerance to 6 lsb; no state
// but the tolerance is kept from one item to the next.
module newton_square_root #(
  parameter int unsigned MAX_ITERATIONS = nsr_pkg::MAX_ITER_DEFAULT,
  parameter int unsigned FRACTION_BITS  = nsr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nsr_in_if.sink    rad_i,
  nsr_out_if.source res_o,
  nsr_cfg_if.sink   cfg_i
);

  import nsr_pkg::*;

  localparam int unsigned DVD_W  = WORD_W + FRACTION_BITS;
  localparam int unsigned ITER_W = $clog2(MAX_ITERATIONS + 1);

  nsr_state_e state_q, state_d;

  logic [TOL_W-1:0]  tol_q;
  logic [WORD_W-1:0] value_q, value_d;
  logic [WORD_W-1:0] x_q, x_d;
  logic [WORD_W-1:0] prev_q, prev_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              flag_q, flag_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_root_q, out_root_d;
  logic              out_flag_q, out_flag_d;

  logic              div_start;
  logic              div_done;
  logic [DVD_W-1:0]  quotient;
  logic [DVD_W:0]    sum;
  logic [WORD_W-1:0] new_guess;
  logic [WORD_W-1:0] delta;
  logic              rad_accept;
  logic              out_free;

  nsr_divider #(
    .DVD_W(DVD_W),
    .DVS_W(WORD_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({value_q, {FRACTION_BITS{1'b0}}}),
    .divisor_i (x_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  assign rad_i.ready         = (state_q == ST_IDLE);
  assign rad_accept          = rad_i.valid && rad_i.ready;
  assign cfg_i.ready         = 1'b1;
  assign res_o.valid         = out_valid_q;
  assign res_o.root          = out_root_q;
  assign res_o.not_converged = out_flag_q;
  assign out_free            = !out_valid_q || res_o.ready;

  always_comb begin
    sum = {1'b0, quotient} + {{(DVD_W + 1 - WORD_W){1'b0}}, x_q};
    // halve, saturating anything above the word
    if (|sum[DVD_W:WORD_W+1]) begin
      new_guess = '1;
    end else begin
      new_guess = sum[WORD_W:1];
    end
    delta = (x_q >= prev_q) ? (x_q - prev_q) : (prev_q - x_q);
  end

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    x_d         = x_q;
    prev_d      = prev_q;
    iter_d      = iter_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q;
    out_root_d  = out_root_q;
    out_flag_d  = out_flag_q;
    div_start   = 1'b0;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (rad_accept) begin
          value_d = rad_i.radicand;
          x_d     = WORD_W'(1) << FRACTION_BITS;
          iter_d  = '0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        prev_d  = x_q;
        x_d     = new_guess;
        iter_d  = iter_q + ITER_W'(1);
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // a zero guess wins over the tolerance test
        if (x_q == '0) begin
          flag_d  = 1'b1;
          state_d = ST_DONE;
        end else if (delta <= {{(WORD_W - TOL_W){1'b0}}, tol_q}) begin
          flag_d  = 1'b0;
          state_d = ST_DONE;
        end else if (iter_q == ITER_W'(MAX_ITERATIONS)) begin
          flag_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_START;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_root_d  = x_q;
          out_flag_d  = flag_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      tol_q       <= TOL_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        tol_q <= cfg_i.tolerance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    x_q        <= x_d;
    prev_q     <= prev_d;
    iter_q     <= iter_d;
    flag_q     <= flag_d;
    out_root_q <= out_root_d;
    out_flag_q <= out_flag_d;
  end

endmodule

// ----- design/nsr_checker.sv -----
// port-level checks for the newton square root block, bound to the top level
module nsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_root_i,
  input logic        out_flag_i
);

  // result held while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped during stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_root_i) && $stable(out_flag_i))
    else $error("result changed during stall");

  // one item in flight: no second radicand right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("radicand taken while busy");

  // a converged root can never be zero, as a zero guess is flagged first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_flag_i |-> out_root_i != 32'd0)
    else $error("converged result with zero root");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (rad_i.valid),
  .in_ready_i (rad_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_root_i (res_o.root),
  .out_flag_i (res_o.not_converged)
);
